// ----- rtl/shape_model_weak_perspective_projection_assert.svh -----
// assertion macros for the weak perspective projection block
// used by the top level; expects clk and rst in the including scope
`ifndef SHAPE_MODEL_WEAK_PERSPECTIVE_PROJECTION_ASSERT_SVH
`define SHAPE_MODEL_WEAK_PERSPECTIVE_PROJECTION_ASSERT_SVH
`ifndef SYNTH
`define SMWPP_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SMWPP_CHECK_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) else $error(msg);
`else
`define SMWPP_CHECK(lbl, prop, msg)
`define SMWPP_CHECK_NEXT(lbl, trig, prop, msg)
`endif
`endif

// ----- rtl/smwpp_pkg.sv -----
// shared constants, tables, types and rounding helper of the projection block
// no dependencies
package smwpp_pkg;

  localparam int MAX_MODES    = 64;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int NUM_STEPS    = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int STEP_W       = 5;
  localparam int MODE_AW      = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;

  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;

  localparam logic [29:0] ATAN_TAB [TAB_LEN] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
    30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
    30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128
  };

  // register indexes
  localparam logic [2:0] REG_SCALE = 3'd0;
  localparam logic [2:0] REG_PITCH = 3'd1;
  localparam logic [2:0] REG_YAW   = 3'd2;
  localparam logic [2:0] REG_ROLL  = 3'd3;
  localparam logic [2:0] REG_OFFX  = 3'd4;
  localparam logic [2:0] REG_OFFY  = 3'd5;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_BASIS = 2'd2;

  typedef struct packed {
    logic               done;
    logic signed [19:0] sin_v;
    logic signed [19:0] cos_v;
  } cordic_res_t;

  // drop 16 fraction bits, nearest, ties away from zero
  function automatic logic signed [66:0] rnd16(input logic signed [66:0] p);
    logic signed [66:0] t;
    t = p + 67'sd32767 + (p[66] ? 67'sd0 : 67'sd1);
    rnd16 = t >>> 16;
  endfunction

endpackage

// ----- rtl/shape_model_weak_perspective_projection.sv -----
// top level of the weak perspective shape model projection
// depends on smwpp_pkg, smwpp_mul, smwpp_cordic and the assertion header
// load and start items are taken in idle; a basis item and a projection run
// on one shared multiplier; not ready while an item is at work
// after reset and after each angle write the rotation rows are rebuilt by the
// cordic and the multiplier, during which no item is taken
// rst is synchronous, active high; result register empty after reset
`include "shape_model_weak_perspective_projection_assert.svh"
module shape_model_weak_perspective_projection (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // mode_index, weight_value, coord_x, coord_y, coord_z
  input  logic [1:0]   s_tuser,   // kind
  input  logic         s_tlast,   // vertex_end
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // image_x, image_y
  output logic         m_tuser    // saturated
);
  import smwpp_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_BAS_MUL   = 4'd1;
  localparam logic [3:0] S_BAS_ACC   = 4'd2;
  localparam logic [3:0] S_PRJ_MUL   = 4'd3;
  localparam logic [3:0] S_PRJ_ACC   = 4'd4;
  localparam logic [3:0] S_HI_MUL    = 4'd5;
  localparam logic [3:0] S_HI_USE    = 4'd6;
  localparam logic [3:0] S_LO_MUL    = 4'd7;
  localparam logic [3:0] S_LO_USE    = 4'd8;
  localparam logic [3:0] S_EMIT      = 4'd9;
  localparam logic [3:0] S_ROT_START = 4'd10;
  localparam logic [3:0] S_ROT_COR   = 4'd11;
  localparam logic [3:0] S_ROT_MUL   = 4'd12;
  localparam logic [3:0] S_ROT_USE   = 4'd13;

  localparam logic signed [48:0] ACC_MAX = 49'sd140737488355327;
  localparam logic signed [20:0] ROW_MAX = 21'sd131071;

  // configuration registers
  logic [23:0]        scale;
  logic signed [15:0] ang [3];
  logic signed [31:0] off_x, off_y;
  logic               pending;

  // item registers
  logic signed [31:0] crd [3];
  logic               vend;
  logic [31:0]        wmem [MAX_MODES];
  logic [31:0]        w_rd;
  logic               w_ok;

  // datapath state
  logic [3:0]         state;
  logic [1:0]         k, a;
  logic               h, row;
  logic [2:0]         p;
  logic signed [47:0] acc [3];
  logic signed [17:0] rows [6];
  logic signed [19:0] sn [3], cs [3];
  logic signed [19:0] t_v, tmp_v;
  logic signed [66:0] pex;
  logic signed [51:0] psum;
  logic [22:0]        hiprod;
  logic signed [31:0] res_x, res_y;
  logic               res_sat;

  logic               s_fire;
  logic [5:0]         in_idx;
  logic               idx_ok;
  logic [MODE_AW-1:0] waddr;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  cordic_res_t        cres;
  logic               ang_wr;

  logic signed [66:0] prod_x, bprod, pfull, pr;
  logic signed [48:0] bsum;
  logic signed [51:0] mag;
  logic               neg;
  logic signed [19:0] rp;
  logic [50:0]        qsum;
  logic signed [36:0] qv, vv;
  logic signed [31:0] off_sel;
  logic [2:0]         ridx;

  function automatic logic signed [17:0] clamp_row(input logic signed [20:0] v);
    if (v > ROW_MAX) clamp_row = 18'sd131071;
    else if (v < -ROW_MAX) clamp_row = -18'sd131071;
    else clamp_row = 18'(v);
  endfunction

  assign s_tready = (state == S_IDLE) && !pending;
  assign s_fire   = s_tvalid && s_tready;
  assign in_idx   = s_tdata[5:0];
  assign idx_ok   = 32'(in_idx) < 32'(MAX_MODES);
  assign waddr    = MODE_AW'(in_idx);
  assign ang_wr   = cfg_we && (cfg_index == REG_PITCH || cfg_index == REG_YAW ||
                               cfg_index == REG_ROLL);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scale  <= 24'd65536;
      ang[0] <= '0;
      ang[1] <= '0;
      ang[2] <= '0;
      off_x  <= '0;
      off_y  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE: scale  <= cfg_data[23:0];
        REG_PITCH: ang[0] <= cfg_data[15:0];
        REG_YAW:   ang[1] <= cfg_data[15:0];
        REG_ROLL:  ang[2] <= cfg_data[15:0];
        REG_OFFX:  off_x  <= cfg_data;
        REG_OFFY:  off_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  // weight memory, read registered at the transaction
  always_ff @(posedge clk) begin
    if (s_fire && s_tuser == KIND_LOAD && idx_ok) wmem[waddr] <= s_tdata[37:6];
    if (s_fire) begin
      w_rd   <= wmem[waddr];
      w_ok   <= idx_ok;
      crd[0] <= s_tdata[69:38];
      crd[1] <= s_tdata[101:70];
      crd[2] <= s_tdata[133:102];
      vend   <= s_tlast;
    end
  end

  // shared multiplier operand select
  assign ridx = row ? (3'd3 + 3'(k)) : 3'(k);
  assign mag  = psum[51] ? -psum : psum;
  assign neg  = psum[51];

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_BAS_MUL: begin
        ma = w_ok ? 33'($signed(w_rd)) : 33'sd0;
        mb = 33'(crd[k]);
      end
      S_PRJ_MUL: begin
        ma = 33'(rows[ridx]);
        mb = h ? 33'($signed(acc[k][47:24])) : $signed({9'd0, acc[k][23:0]});
      end
      S_HI_MUL: begin
        ma = $signed({8'd0, mag[50:26]});
        mb = $signed({9'd0, scale});
      end
      S_LO_MUL: begin
        ma = $signed({7'd0, mag[25:0]});
        mb = $signed({9'd0, scale});
      end
      S_ROT_MUL: begin
        case (p)
          3'd0: begin ma = 33'(sn[0]); mb = 33'(sn[1]); end
          3'd1: begin ma = 33'(cs[1]); mb = 33'(cs[2]); end
          3'd2: begin ma = 33'(cs[1]); mb = 33'(sn[2]); end
          3'd3: begin ma = 33'(cs[0]); mb = 33'(sn[2]); end
          3'd4: begin ma = 33'(cs[2]); mb = 33'(t_v); end
          3'd5: begin ma = 33'(cs[0]); mb = 33'(cs[2]); end
          3'd6: begin ma = 33'(t_v); mb = 33'(sn[2]); end
          default: begin ma = 33'(cs[1]); mb = 33'(sn[0]); end
        endcase
      end
      default: ;
    endcase
  end

  smwpp_mul u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (prod)
  );

  smwpp_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_ROT_START),
    .angle (ang[a]),
    .res   (cres)
  );

  // rounding, accumulation and scaling arithmetic
  assign prod_x  = 67'(prod);
  assign bprod   = rnd16(prod_x);
  assign bsum    = 49'(acc[k]) + 49'($signed(bprod[47:0]));
  assign pfull   = pex + (prod_x <<< 24);
  assign pr      = rnd16(pfull);
  assign rp      = 20'(bprod);
  assign qsum    = {2'd0, hiprod, 26'd0} + 51'(prod[49:0]) + 51'd32768;
  assign qv      = neg ? -$signed({2'd0, qsum[50:16]}) : $signed({2'd0, qsum[50:16]});
  assign off_sel = row ? off_y : off_x;
  assign vv      = qv + 37'(off_sel);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pending  <= 1'b1;
      m_tvalid <= 1'b0;
      acc[0]   <= '0;
      acc[1]   <= '0;
      acc[2]   <= '0;
      k <= '0; a <= '0; h <= 1'b0; row <= 1'b0; p <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_EMIT) m_tvalid <= 1'b0;
      if (ang_wr) pending <= 1'b1;
      case (state)
        S_IDLE: begin
          if (pending) begin
            if (!ang_wr) pending <= 1'b0;
            a     <= '0;
            state <= S_ROT_START;
          end else if (s_fire) begin
            case (s_tuser)
              KIND_START: begin
                acc[0] <= 48'($signed(s_tdata[69:38]));
                acc[1] <= 48'($signed(s_tdata[101:70]));
                acc[2] <= 48'($signed(s_tdata[133:102]));
                if (s_tlast) begin
                  row <= 1'b0; k <= '0; h <= 1'b0; res_sat <= 1'b0;
                  state <= S_PRJ_MUL;
                end
              end
              KIND_BASIS: begin
                k     <= '0;
                state <= S_BAS_MUL;
              end
              default: ;
            endcase
          end
        end
        S_BAS_MUL: state <= S_BAS_ACC;
        S_BAS_ACC: begin
          if (bsum > ACC_MAX) acc[k] <= 48'sd140737488355327;
          else if (bsum < -ACC_MAX) acc[k] <= -48'sd140737488355327;
          else acc[k] <= 48'(bsum);
          if (k == 2'd2) begin
            k <= '0;
            if (vend) begin
              row <= 1'b0; h <= 1'b0; res_sat <= 1'b0;
              state <= S_PRJ_MUL;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            k     <= k + 1'b1;
            state <= S_BAS_MUL;
          end
        end
        S_PRJ_MUL: state <= S_PRJ_ACC;
        S_PRJ_ACC: begin
          if (!h) begin
            pex   <= prod_x;
            h     <= 1'b1;
            state <= S_PRJ_MUL;
          end else begin
            h <= 1'b0;
            if (k == 2'd0) psum <= $signed(pr[51:0]);
            else psum <= psum + $signed(pr[51:0]);
            if (k == 2'd2) begin
              k     <= '0;
              state <= S_HI_MUL;
            end else begin
              k     <= k + 1'b1;
              state <= S_PRJ_MUL;
            end
          end
        end
        S_HI_MUL: state <= S_HI_USE;
        S_HI_USE: begin
          if (prod >= 66'sd8388608) begin
            res_sat <= 1'b1;
            if (row) res_y <= neg ? 32'sh80000000 : 32'sh7fffffff;
            else res_x <= neg ? 32'sh80000000 : 32'sh7fffffff;
            if (row) state <= S_EMIT;
            else begin
              row   <= 1'b1;
              state <= S_PRJ_MUL;
            end
          end else begin
            hiprod <= prod[22:0];
            state  <= S_LO_MUL;
          end
        end
        S_LO_MUL: state <= S_LO_USE;
        S_LO_USE: begin
          // clamp to 32 bits
          if (vv > 37'sd2147483647) begin
            res_sat <= 1'b1;
            if (row) res_y <= 32'sh7fffffff; else res_x <= 32'sh7fffffff;
          end else if (vv < -37'sd2147483648) begin
            res_sat <= 1'b1;
            if (row) res_y <= 32'sh80000000; else res_x <= 32'sh80000000;
          end else begin
            if (row) res_y <= 32'(vv); else res_x <= 32'(vv);
          end
          if (row) state <= S_EMIT;
          else begin
            row   <= 1'b1;
            state <= S_PRJ_MUL;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {res_y, res_x};
            m_tuser  <= res_sat;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_ROT_START: state <= S_ROT_COR;
        S_ROT_COR: begin
          if (cres.done) begin
            sn[a] <= cres.sin_v;
            cs[a] <= cres.cos_v;
            if (a == 2'd2) begin
              p     <= '0;
              state <= S_ROT_MUL;
            end else begin
              a     <= a + 1'b1;
              state <= S_ROT_START;
            end
          end
        end
        S_ROT_MUL: state <= S_ROT_USE;
        S_ROT_USE: begin
          case (p)
            3'd0: t_v     <= rp;
            3'd1: rows[0] <= clamp_row(21'(rp));
            3'd2: rows[1] <= clamp_row(-21'(rp));
            3'd3: tmp_v   <= rp;
            3'd4: rows[3] <= clamp_row(21'(tmp_v) + 21'(rp));
            3'd5: tmp_v   <= rp;
            3'd6: rows[4] <= clamp_row(21'(tmp_v) - 21'(rp));
            default: begin
              rows[5] <= clamp_row(-21'(rp));
              rows[2] <= clamp_row(21'(sn[1]));
            end
          endcase
          if (p == 3'd7) state <= S_IDLE;
          else begin
            p     <= p + 1'b1;
            state <= S_ROT_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SMWPP_CHECK(a_emit_src, $rose(m_tvalid) |-> $past(state) == S_EMIT, "result not from emit")
  `SMWPP_CHECK(a_cordic_done, cres.done |-> state == S_ROT_COR, "cordic done out of build")
  `SMWPP_CHECK_NEXT(a_basis_go, s_fire && s_tuser == KIND_BASIS, state == S_BAS_MUL, "basis lost")

endmodule

// ----- rtl/smwpp_mul.sv -----
// shared signed multiplier with registered product
// depends on nothing but the clock
module smwpp_mul (
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- rtl/smwpp_cordic.sv -----
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on smwpp_pkg for the arctangent table and gain
module smwpp_cordic (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [15:0]       angle,
  output smwpp_pkg::cordic_res_t   res
);
  import smwpp_pkg::*;

  logic signed [32:0] x, y;
  logic signed [34:0] z;
  logic [STEP_W-1:0]  i;
  logic               busy, done, neg;
  logic signed [34:0] z_in, z_sh, at;
  logic signed [32:0] dx, dy;
  logic signed [33:0] xt, yt;
  logic signed [19:0] xr, yr;

  // angle in 2^-13 rad, shifted to 2^-30 rad
  assign z_in = 35'(angle);
  assign z_sh = z_in <<< 17;
  assign at   = {5'd0, ATAN_TAB[i]};
  assign dx   = y >>> i;
  assign dy   = x >>> i;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= CORDIC_GAIN;
        y    <= '0;
        i    <= '0;
        busy <= 1'b1;
        // fold to +-pi/2
        if (z_sh > HALF_PI_Q30) begin
          z   <= z_sh - PI_Q30;
          neg <= 1'b1;
        end else if (z_sh < -HALF_PI_Q30) begin
          z   <= z_sh + PI_Q30;
          neg <= 1'b1;
        end else begin
          z   <= z_sh;
          neg <= 1'b0;
        end
      end else if (busy) begin
        if (!z[34]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        i <= i + 1'b1;
        if (i == STEP_W'(NUM_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // round to q1.16 and undo the fold
  assign xt = 34'(x) + 34'sd8191 + (x[32] ? 34'sd0 : 34'sd1);
  assign yt = 34'(y) + 34'sd8191 + (y[32] ? 34'sd0 : 34'sd1);
  assign xr = 20'(xt >>> 14);
  assign yr = 20'(yt >>> 14);

  assign res.done  = done;
  assign res.cos_v = neg ? -xr : xr;
  assign res.sin_v = neg ? -yr : yr;

endmodule
